### rtl/h2d_pkg.sv
package h2d_pkg;

  localparam int DEC_DIGITS = 64;
  localparam int DIG_W      = 4;
  localparam int CNT_W      = $clog2(DEC_DIGITS + 1);

  localparam logic [7:0] ASC_0 = 8'd48;
  localparam logic [7:0] ASC_9 = 8'd57;
  localparam logic [7:0] ASC_A = 8'd65;
  localparam logic [7:0] ASC_F = 8'd70;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_DBL   = 2'd1,
    CELL_SHIFT = 2'd2,
    CELL_CLR   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     bit_in;
  } cell_ctrl_t;

  // Bit 4 set marks a character that is not an accepted hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = {1'b1, 4'd0};
    if (c >= ASC_0 && c <= ASC_9) begin
      r = {1'b0, 4'(c - ASC_0)};
    end else if (c >= ASC_A && c <= ASC_F) begin
      r = {1'b0, 4'(c - ASC_A) + 4'd10};
    end
    return r;
  endfunction

endpackage

### rtl/h2d_cell.sv
module h2d_cell
  import h2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_op_t         op,
  input  logic             bit_in,
  input  logic [DIG_W-1:0] digit_in,
  output logic             carry_out,
  output logic [DIG_W-1:0] digit_out
);

  logic [DIG_W-1:0] digit_r;
  logic [DIG_W-1:0] digit_nxt;
  logic [DIG_W-1:0] adj;

  assign carry_out = (digit_r >= 4'd5);
  assign adj       = carry_out ? (digit_r + 4'd3) : digit_r;
  assign digit_out = digit_r;

  always_comb begin
    unique case (op)
      CELL_HOLD:  digit_nxt = digit_r;
      CELL_DBL:   digit_nxt = {adj[DIG_W-2:0], bit_in};
      CELL_SHIFT: digit_nxt = digit_in;
      CELL_CLR:   digit_nxt = '0;
      default:    digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

### rtl/h2d_chain.sv
module h2d_chain
  import h2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  output logic             top_carry,
  output logic [DIG_W-1:0] top_digit
);

  logic             carry [DEC_DIGITS];
  logic [DIG_W-1:0] digit [DEC_DIGITS];

  genvar i;
  generate
    for (i = 0; i < DEC_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
        h2d_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .op        (ctrl.op),
          .bit_in    (ctrl.bit_in),
          .digit_in  ('0),
          .carry_out (carry[i]),
          .digit_out (digit[i])
        );
      end else begin : g_next
        h2d_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .op        (ctrl.op),
          .bit_in    (carry[i-1]),
          .digit_in  (digit[i-1]),
          .carry_out (carry[i]),
          .digit_out (digit[i])
        );
      end
    end
  endgenerate

  assign top_carry = carry[DEC_DIGITS-1];
  assign top_digit = digit[DEC_DIGITS-1];

endmodule

### rtl/hex_string_to_decimal_digits_top.sv
// Channel   Handshake             Payload
// input     start / busy          in_char_code, in_last_char
// result    out_strobe            out_dec_digit, out_last_digit, out_status
//
// A hex digit goes through the row of decimal cells one bit per cycle, its top bit
// in its accept cycle and the other three in S_DABBLE.
// An invalid character, or one that follows an error, does not leave S_IDLE.
// A last digit that fits moves to S_EMIT to shift the store out of the top cell,
// one registered result per cycle from the first nonzero on, a lone 0 if all zero.
// Reset is synchronous and clears the cells and the error flags.
// Results cannot be stalled; each is shown for exactly one cycle.
module hex_string_to_decimal_digits_top
  import h2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       in_char_code,
  input  logic             in_last_char,
  output logic             out_strobe,
  output logic [DIG_W-1:0] out_dec_digit,
  output logic             out_last_digit,
  output logic [1:0]       out_status
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DABBLE = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       vbits_r, vbits_nxt;
  logic [1:0]       bcnt_r, bcnt_nxt;
  logic             last_r, last_nxt;
  logic             bad_r, bad_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             strobe_r, strobe_nxt;
  logic [DIG_W-1:0] digit_r, digit_nxt;
  logic             olast_r, olast_nxt;
  status_t          status_r, status_nxt;

  cell_ctrl_t       ctrl;
  logic             top_carry;
  logic [DIG_W-1:0] top_digit;
  logic [4:0]       hv;
  logic             ovf_now;

  h2d_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .top_carry (top_carry),
    .top_digit (top_digit)
  );

  assign hv      = hex_value(in_char_code);
  assign ovf_now = ovf_r | top_carry;
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    vbits_nxt   = vbits_r;
    bcnt_nxt    = bcnt_r;
    last_nxt    = last_r;
    bad_nxt     = bad_r;
    ovf_nxt     = ovf_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    strobe_nxt  = 1'b0;
    digit_nxt   = '0;
    olast_nxt   = 1'b0;
    status_nxt  = ST_OK;
    ctrl.op     = CELL_HOLD;
    ctrl.bit_in = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt = in_last_char;
          if (hv[4]) begin
            ctrl.op = CELL_CLR;
            bad_nxt = 1'b1;
            if (in_last_char) begin
              strobe_nxt = 1'b1;
              olast_nxt  = 1'b1;
              status_nxt = ST_BAD;
              bad_nxt    = 1'b0;
              ovf_nxt    = 1'b0;
            end
          end else if (bad_r || ovf_r) begin
            if (in_last_char) begin
              strobe_nxt = 1'b1;
              olast_nxt  = 1'b1;
              status_nxt = bad_r ? ST_BAD : ST_OVF;
              bad_nxt    = 1'b0;
              ovf_nxt    = 1'b0;
            end
          end else begin
            ctrl.op     = CELL_DBL;
            ctrl.bit_in = hv[3];
            vbits_nxt   = hv[2:0];
            bcnt_nxt    = 2'd2;
            ovf_nxt     = ovf_now;
            state_nxt   = S_DABBLE;
          end
        end
      end
      S_DABBLE: begin
        ctrl.op     = CELL_DBL;
        ctrl.bit_in = vbits_r[2];
        vbits_nxt   = {vbits_r[1:0], 1'b0};
        ovf_nxt     = ovf_now;
        bcnt_nxt    = bcnt_r - 2'd1;
        if (bcnt_r == 2'd0) begin
          state_nxt = S_IDLE;
          if (ovf_now) begin
            ctrl.op = CELL_CLR;
            if (last_r) begin
              strobe_nxt = 1'b1;
              olast_nxt  = 1'b1;
              status_nxt = ST_OVF;
              ovf_nxt    = 1'b0;
            end
          end else if (last_r) begin
            state_nxt   = S_EMIT;
            cnt_nxt     = CNT_W'(DEC_DIGITS);
            started_nxt = 1'b0;
          end
        end
      end
      S_EMIT: begin
        ctrl.op = CELL_SHIFT;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (started_r || (top_digit != '0) || (cnt_r == CNT_W'(1))) begin
          strobe_nxt  = 1'b1;
          digit_nxt   = top_digit;
          olast_nxt   = (cnt_r == CNT_W'(1));
          started_nxt = 1'b1;
        end
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bad_r     <= 1'b0;
      ovf_r     <= 1'b0;
      strobe_r  <= 1'b0;
      bcnt_r    <= '0;
      cnt_r     <= '0;
      started_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bad_r     <= bad_nxt;
      ovf_r     <= ovf_nxt;
      strobe_r  <= strobe_nxt;
      bcnt_r    <= bcnt_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vbits_r  <= vbits_nxt;
    digit_r  <= digit_nxt;
    olast_r  <= olast_nxt;
    status_r <= status_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_dec_digit  = digit_r;
  assign out_last_digit = olast_r;
  assign out_status     = status_r;

`ifndef SYNTHESIS
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_dec_digit <= 4'd9))
    else $error("decimal digit out of range");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_OK)) |-> (out_last_digit && (out_dec_digit == '0)))
    else $error("error transaction is not a single final zero");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_digit) |-> !busy)
    else $error("still busy after the final result");

  a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_char) |=> !out_strobe)
    else $error("result after a character that is not the last");
`endif

endmodule
